>>> design/spectrum_bar_peak_tracker_defines.svh
// Assertion macros for the spectrum bar/peak tracker checker.
// Needs signals named clk and arst_n in the scope of each use.
`ifndef SPECTRUM_BAR_PEAK_TRACKER_DEFINES_SVH
`define SPECTRUM_BAR_PEAK_TRACKER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define SBPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SBPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sbpt_pkg.sv
// Shared widths, register codes and types of the spectrum bar/peak tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbpt_pkg;

	localparam int BIN_W         = 8;
	localparam int MAG_W         = 16;
	localparam int LEVEL_W       = 24;
	localparam int COEFF_W       = 16;
	localparam int FRAC_W        = LEVEL_W - MAG_W;
	localparam int CFG_IDX_W     = 8;
	localparam int BIN_COUNT_DEF = 256;

	// products of the decay blend
	localparam int KEEP_W = LEVEL_W + COEFF_W;
	localparam int TAKE_W = COEFF_W + 1 + MAG_W;
	localparam int SUM_W  = KEEP_W + 1;

	localparam logic [COEFF_W:0]   COEFF_ONE = {1'b1, {COEFF_W{1'b0}}};
	localparam logic [LEVEL_W-1:0] MAX_LEVEL = {{MAG_W{1'b1}}, {FRAC_W{1'b0}}};

	localparam logic [COEFF_W-1:0] BAR_DECAY_RST  = 16'd45875;
	localparam logic [COEFF_W-1:0] PEAK_DECAY_RST = 16'd62259;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_DECAY  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DECAY = 8'd1;

	typedef logic [LEVEL_W-1:0] level_t;

	// one store's blend, between the multiply and the add stage
	typedef struct packed {
		logic              attack;
		logic [KEEP_W-1:0] keep;
		logic [TAKE_W-1:0] take;
	} blend_t;

endpackage

`default_nettype wire

>>> design/sbpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Uses sbpt_pkg for default sizes only.
`default_nettype none

module sbpt_ram
	import sbpt_pkg::*;
#(
	parameter int WIDTH = LEVEL_W,
	parameter int DEPTH = BIN_COUNT_DEF,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the contents before a write at the same edge
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> design/spectrum_bar_peak_tracker.sv
// Top level of the spectrum bar/peak tracker: bar and peak level stores per bin.
// Depends on sbpt_pkg and sbpt_ram.
//
//  channel   signals                                   handshake
//  --------  ----------------------------------------  ----------------------
//  item      bin_number, magnitude                     item_valid / item_stall
//  result    bin_out, bar_level, peak_level            result_valid / result_stall
//  config    cfg_index, cfg_data                       cfg_valid / cfg_ready
//
// One item per cycle unless item_stall is high. An item passes stage 1, stage 2
// and the output register before its result appears on the result channel.
// An item directly behind an item for the same bin waits in stage 1: the level
// update loop runs through the multiply stage and the add stage.
// After reset the stores are zeroed, one entry a cycle, with item_stall high.
// result_stall freezes the whole pipeline while a result is held; nothing is lost.
`default_nettype none

module spectrum_bar_peak_tracker
	import sbpt_pkg::*;
#(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic [BIN_W-1:0]     bin_number,
	input  wire logic [MAG_W-1:0]     magnitude,

	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic      [BIN_W-1:0]     bin_out,
	output logic      [LEVEL_W-1:0]   bar_level,
	output logic      [LEVEL_W-1:0]   peak_level,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COEFF_W-1:0]   cfg_data
);

	localparam int ADDR_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int IDX_W  = (ADDR_W > BIN_W) ? ADDR_W : BIN_W;

	// blend, first half: compare and both products
	function automatic blend_t blend_mul(input level_t old, input logic [MAG_W-1:0] mag,
			input logic [COEFF_W-1:0] coeff);
		blend_t b;
		level_t mag_q;
		mag_q    = {mag, {FRAC_W{1'b0}}};
		b.attack = mag_q > old;
		b.keep   = KEEP_W'(coeff) * KEEP_W'(old);
		b.take   = TAKE_W'(COEFF_ONE - {1'b0, coeff}) * TAKE_W'(mag);
		return b;
	endfunction

	// blend, second half: sum, truncate, pick attack or decay
	function automatic level_t blend_add(input blend_t b, input logic [MAG_W-1:0] mag);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(b.keep) + SUM_W'({b.take, {FRAC_W{1'b0}}});
		return b.attack ? {mag, {FRAC_W{1'b0}}} : sum[COEFF_W +: LEVEL_W];
	endfunction

	// configuration registers
	logic [COEFF_W-1:0] bar_coeff_q;
	logic [COEFF_W-1:0] peak_coeff_q;

	// clearing pass
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// pipeline control
	logic advance;
	logic hazard;
	logic accept;

	// stage 1: item registered, store entries read
	logic              valid_s1;
	logic [BIN_W-1:0]  bin_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic              inrange_s1;
	logic [ADDR_W-1:0] addr_s1;
	level_t            bar_rd;
	level_t            peak_rd;
	level_t            bar_old;
	level_t            peak_old;
	logic              fwd;

	// stage 2: products registered
	logic              valid_s2;
	logic [BIN_W-1:0]  bin_s2;
	logic [MAG_W-1:0]  mag_s2;
	logic              inrange_s2;
	logic [ADDR_W-1:0] addr_s2;
	blend_t            bar_mul_s2;
	blend_t            peak_mul_s2;
	level_t            bar_new;
	level_t            peak_new;

	// stage 3: output register, also the forwarding source
	logic              valid_s3;
	logic [BIN_W-1:0]  bin_s3;
	logic              inrange_s3;
	logic [ADDR_W-1:0] addr_s3;
	level_t            bar_s3;
	level_t            peak_s3;

	// store ports
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	level_t            bar_wr;
	level_t            peak_wr;
	logic [IDX_W-1:0]  bin_ext;
	logic [ADDR_W-1:0] rd_addr;
	logic              bin_inrange;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_coeff_q  <= BAR_DECAY_RST;
			peak_coeff_q <= PEAK_DECAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BAR_DECAY:  bar_coeff_q  <= cfg_data;
				CFG_PEAK_DECAY: peak_coeff_q <= cfg_data;
				default: ;   // drop writes to unknown registers
			endcase
		end
	end

	// Zero both stores after reset, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(BIN_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Advance everything unless the output beat is held. An item in stage 1 for
	// the same bin as the item in stage 2 waits until that item reaches the output
	// register, so that its old level can come from there.
	assign advance    = !(valid_s3 && result_stall);
	assign hazard     = valid_s1 && valid_s2 && inrange_s1 && inrange_s2 && (addr_s1 == addr_s2);
	assign item_stall = !advance || hazard || clearing_q;
	assign accept     = item_valid && !item_stall;

	assign bin_ext     = IDX_W'(bin_number);
	assign rd_addr     = bin_ext[ADDR_W-1:0];
	assign bin_inrange = 32'(bin_number) < BIN_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
			valid_s2 <= valid_s1 && !hazard;
			if (!hazard) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_s1     <= bin_number;
			mag_s1     <= magnitude;
			inrange_s1 <= bin_inrange;
			addr_s1    <= rd_addr;
		end
		if (advance && !hazard) begin
			bin_s2      <= bin_s1;
			mag_s2      <= mag_s1;
			inrange_s2  <= inrange_s1;
			addr_s2     <= addr_s1;
			bar_mul_s2  <= blend_mul(bar_old, mag_s1, bar_coeff_q);
			peak_mul_s2 <= blend_mul(peak_old, mag_s1, peak_coeff_q);
		end
		if (advance) begin
			bin_s3     <= bin_s2;
			inrange_s3 <= inrange_s2;
			addr_s3    <= addr_s2;
			bar_s3     <= inrange_s2 ? bar_new : '0;
			peak_s3    <= inrange_s2 ? peak_new : '0;
		end
	end

	// The store read misses the write made at the same edge; take that level
	// from the output register instead.
	assign fwd      = valid_s3 && inrange_s3 && (addr_s3 == addr_s1);
	assign bar_old  = fwd ? bar_s3 : bar_rd;
	assign peak_old = fwd ? peak_s3 : peak_rd;

	assign bar_new  = blend_add(bar_mul_s2, mag_s2);
	assign peak_new = blend_add(peak_mul_s2, mag_s2);

	// write back as the item leaves stage 2; the clearing pass owns the port
	// while the pipeline is still empty
	assign wr_en   = clearing_q || (advance && valid_s2 && inrange_s2);
	assign wr_addr = clearing_q ? clr_addr_q : addr_s2;
	assign bar_wr  = clearing_q ? '0 : bar_new;
	assign peak_wr = clearing_q ? '0 : peak_new;

	sbpt_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (BIN_COUNT)
	) u_bar_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (bar_wr),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (bar_rd)
	);

	sbpt_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (BIN_COUNT)
	) u_peak_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (peak_wr),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (peak_rd)
	);

	assign result_valid = valid_s3;
	assign bin_out      = bin_s3;
	assign bar_level    = bar_s3;
	assign peak_level   = peak_s3;

endmodule

`default_nettype wire

>>> design/sbpt_checker.sv
// Port-level checks of the spectrum bar/peak tracker, bound to its top level.
// Depends on sbpt_pkg and spectrum_bar_peak_tracker_defines.svh.
`default_nettype none

`include "spectrum_bar_peak_tracker_defines.svh"

module sbpt_checker
	import sbpt_pkg::*;
#(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic [BIN_W-1:0]   bin_out,
	input wire logic [LEVEL_W-1:0] bar_level,
	input wire logic [LEVEL_W-1:0] peak_level
);

	logic                         held;
	logic [BIN_W+2*LEVEL_W-1:0]   beat;
	logic                         far_bin;
	logic                         levels_zero;

	assign held        = result_valid && result_stall;
	assign beat        = {bin_out, bar_level, peak_level};
	assign far_bin     = result_valid && (32'(bin_out) >= BIN_COUNT);
	assign levels_zero = (bar_level == '0) && (peak_level == '0);

	// a held result beat stays put
	`SBPT_ASSERT_NEXT(a_hold, held, result_valid && $stable(beat), "held result beat changed")

	// a bin beyond the store reports zero levels
	`SBPT_ASSERT_NOW(a_out_of_range, far_bin, levels_zero, "out-of-range bin reported a level")

	// a blend never exceeds the largest magnitude
	`SBPT_ASSERT_NOW(a_bar_bound, result_valid, bar_level <= MAX_LEVEL, "bar level above full scale")

	`SBPT_ASSERT_NOW(a_peak_bound, result_valid, peak_level <= MAX_LEVEL, "peak level above full scale")

endmodule

bind spectrum_bar_peak_tracker sbpt_checker #(.BIN_COUNT(BIN_COUNT)) u_sbpt_checker (.*);

`default_nettype wire

>>> bench/spectrum_bar_peak_tracker_tb.sv
// Self-checking bench for spectrum_bar_peak_tracker: bar and peak level tracking per bin.
// Depends on sbpt_pkg and the block's RTL; a scoreboard class predicts every result beat.
// Directed items come first, then random items under several coefficient settings.
`default_nettype none

module spectrum_bar_peak_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbpt_pkg::*;

	localparam int NBINS          = BIN_COUNT_DEF;
	localparam int ITEMS_PER_LOT  = 400;
	localparam int LOTS           = 5;
	localparam int IDLE_PCT       = 24;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 10;
	localparam int MAX_PRINTED    = 100;

	// one result beat as the block should report it
	typedef struct packed {
		logic [BIN_W-1:0] bin;
		level_t           bar;
		level_t           peak;
	} level_report_t;

	// Level predictor plus the queue of result beats still owed by the block.
	class meter_scoreboard;
		level_t             bar_mem[NBINS];
		level_t             peak_mem[NBINS];
		logic [COEFF_W-1:0] bar_coeff;
		logic [COEFF_W-1:0] peak_coeff;
		level_report_t      due[$];
		int                 errors;

		function new();
			foreach (bar_mem[i]) begin
				bar_mem[i]  = '0;
				peak_mem[i] = '0;
			end
			bar_coeff  = BAR_DECAY_RST;
			peak_coeff = PEAK_DECAY_RST;
			errors     = 0;
		endfunction

		// Instant attack, otherwise a truncating convex blend of old level and magnitude.
		function level_t blend_level(level_t old, level_t mag_q, logic [COEFF_W-1:0] coeff);
			logic [47:0] keep;
			logic [47:0] take;
			if (mag_q > old)
				return mag_q;
			keep = 48'(coeff) * 48'(old);
			take = (48'(COEFF_ONE) - 48'(coeff)) * 48'(mag_q);
			return level_t'((keep + take) >> COEFF_W);
		endfunction

		// Unknown indexes are dropped by the block, so drop them here too.
		function void set_coeff(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] data);
			case (idx)
				CFG_BAR_DECAY: bar_coeff = data;
				CFG_PEAK_DECAY: peak_coeff = data;
				default: ;
			endcase
		endfunction

		function void note_item(logic [BIN_W-1:0] b, logic [MAG_W-1:0] m);
			level_t        mag_q;
			level_report_t r;
			mag_q  = {m, {FRAC_W{1'b0}}};
			r.bin  = b;
			r.bar  = '0;
			r.peak = '0;
			// a bin past the store depth leaves both stores alone and reports zero levels
			if (int'(b) < NBINS) begin
				bar_mem[b]  = blend_level(bar_mem[b], mag_q, bar_coeff);
				peak_mem[b] = blend_level(peak_mem[b], mag_q, peak_coeff);
				r.bar       = bar_mem[b];
				r.peak      = peak_mem[b];
			end
			due.push_back(r);
		endfunction

		function int pending();
			return due.size();
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(input logic [BIN_W-1:0] b, input level_t bar, input level_t peak);
			level_report_t want;
			if (due.size() == 0) begin
				report($sformatf("result beat for bin %0d with nothing expected", b));
				return;
			end
			want = due.pop_front();
			if (b !== want.bin)
				report($sformatf("bin_out got %0d want %0d", b, want.bin));
			if (bar !== want.bar)
				report($sformatf("bin %0d bar_level got %h want %h", want.bin, bar, want.bar));
			if (peak !== want.peak)
				report($sformatf("bin %0d peak_level got %h want %h", want.bin, peak, want.peak));
		endtask

		task close_out();
			if (due.size() != 0)
				report($sformatf("%0d result beats never arrived", due.size()));
		endtask
	endclass

	// Hold every input at a known value from time zero.
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	logic [BIN_W-1:0]     bin_number   = '0;
	logic [MAG_W-1:0]     magnitude    = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [BIN_W-1:0]     bin_out;
	level_t               bar_level;
	level_t               peak_level;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [COEFF_W-1:0]   cfg_data     = '0;

	// Set for one lot of items: neither side idles while it is high.
	logic                 calm         = 1'b0;

	meter_scoreboard sb = new();

	spectrum_bar_peak_tracker #(
		.BIN_COUNT(NBINS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.bin_number  (bin_number),
		.magnitude   (magnitude),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.bin_out     (bin_out),
		.bar_level   (bar_level),
		.peak_level  (peak_level),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	// Receiver: stall at random, never while calm. Drawn fresh at every edge, so stall
	// runs of any length land on every stage of the pipeline.
	always @(posedge clk) begin
		if (calm)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(99) < IDLE_PCT);
	end

	// Check every result beat. Sampling at the edge sees the values from before it.
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && !result_stall)
			sb.check_result(bin_out, bar_level, peak_level);
	end

	// Watchdog: count edges that move no beat on any channel.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_stall === 1'b0) ||
					(result_valid === 1'b1 && !result_stall) ||
					(cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// Drop valid for one cycle and scramble the idle payload.
	task automatic pause_sender();
		item_valid <= 1'b0;
		bin_number <= BIN_W'($urandom);
		magnitude  <= MAG_W'($urandom);
		@(posedge clk);
	endtask

	// Present one item and hold it until the beat is taken. Valid is left high so
	// that a following item goes out back to back.
	task automatic send_item(input logic [BIN_W-1:0] b, input logic [MAG_W-1:0] m);
		item_valid <= 1'b1;
		bin_number <= b;
		magnitude  <= m;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		sb.note_item(b, m);
	endtask

	// Random gaps in front of each item, unless calm.
	task automatic feed(input logic [BIN_W-1:0] b, input logic [MAG_W-1:0] m);
		while (!calm && $urandom_range(99) < IDLE_PCT)
			pause_sender();
		send_item(b, m);
	endtask

	// Hold the sender until every owed result beat has been taken.
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One register write; valid stays high for a write that follows.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		sb.set_coeff(idx, data);
	endtask

	// Call only while the block is idle. Each setting starts with a write to an
	// unused index, which must leave both coefficients alone.
	task automatic program_coeffs(input logic [COEFF_W-1:0] bar_c, input logic [COEFF_W-1:0] peak_c);
		write_reg(CFG_IDX_W'($urandom_range(255, 2)), COEFF_W'($urandom));
		write_reg(CFG_BAR_DECAY, bar_c);
		write_reg(CFG_PEAK_DECAY, peak_c);
		cfg_valid <= 1'b0;
	endtask

	// Mostly a few hot bins and repeats of the last bin, so levels decay over many
	// hits and same-bin beats land back to back; the rest spans the whole index.
	function automatic logic [BIN_W-1:0] pick_bin(logic [BIN_W-1:0] last_bin);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20)
			return last_bin;
		if (r < 70)
			return BIN_W'($urandom_range(7));
		return BIN_W'($urandom);
	endfunction

	// Zeros let levels fall, full scale drives attack, small values probe the fraction.
	function automatic logic [MAG_W-1:0] pick_magnitude();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 12)
			return '0;
		if (r < 20)
			return '1;
		if (r < 45)
			return MAG_W'($urandom_range(255));
		return MAG_W'($urandom);
	endfunction

	initial begin
		logic [BIN_W-1:0]   last_bin;
		logic [COEFF_W-1:0] bar_c;
		logic [COEFF_W-1:0] peak_c;

		last_bin = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset coefficients. The first item waits out the store clearing pass.
		feed(8'd0, 16'hFFFF);    // full scale attack
		feed(8'd0, 16'h0000);    // decay toward zero, three times
		feed(8'd0, 16'h0000);
		feed(8'd0, 16'h0000);
		feed(8'd255, 16'h0001);  // top bin, smallest attack
		feed(8'd255, 16'h0001);  // equal magnitude keeps the level
		feed(8'd255, 16'h0000);
		feed(8'd1, 16'h8000);
		feed(8'd1, 16'h7FFF);
		feed(8'd1, 16'h5555);
		feed(8'd2, 16'hAAAA);
		feed(8'd2, 16'hAAAA);
		feed(8'd128, 16'hFFFF);
		feed(8'd128, 16'hFFFE);

		// Zero coefficients: both levels follow the magnitude exactly.
		drain_results();
		program_coeffs('0, '0);
		feed(8'd3, 16'h1234);
		feed(8'd3, 16'h0001);
		feed(8'd3, 16'h0000);
		feed(8'd3, 16'hFFFF);

		// Largest coefficients: levels barely move on decay.
		drain_results();
		program_coeffs('1, '1);
		feed(8'd3, 16'h0000);
		feed(8'd3, 16'h0000);

		// Random lots, each under its own setting; every boundary drains the pipeline.
		for (int lot = 0; lot < LOTS; lot++) begin
			drain_results();
			case (lot)
				0: begin bar_c = '1; peak_c = '0; end
				1: begin bar_c = '0; peak_c = '1; end
				2: begin bar_c = BAR_DECAY_RST; peak_c = PEAK_DECAY_RST; end
				default: begin bar_c = COEFF_W'($urandom); peak_c = COEFF_W'($urandom); end
			endcase
			program_coeffs(bar_c, peak_c);
			calm <= (lot == 2);
			for (int n = 0; n < ITEMS_PER_LOT; n++) begin
				last_bin = pick_bin(last_bin);
				feed(last_bin, pick_magnitude());
			end
		end

		// Let the last beats out, then allow the pipeline depth for strays.
		calm <= 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
